FILE: rtl/n2k_fpf_pkg.sv
package n2k_fpf_pkg;

    // Identifier layout
    localparam logic [31:0] EFF_FLAG   = 32'h8000_0000;
    localparam int          PGN_BITS   = 18;
    localparam int          PRIO_SHIFT = 26;
    localparam int          PRIO_BITS  = 3;
    localparam int          DST_SHIFT  = 8;

    // Frame geometry
    localparam int          FRAME_BYTES = 8;
    localparam logic [7:0]  SRC_RESET   = 8'd4;

    // Fill count after the fast-packet header bytes of frame 0 / later frames
    localparam logic [3:0]  FILL_HDR_FIRST = 4'd2;
    localparam logic [3:0]  FILL_HDR_NEXT  = 4'd1;

    typedef struct packed {
        logic        first;
        logic [2:0]  priority_req;
        logic [23:0] pgn;
        logic [7:0]  destination;
        logic [7:0]  msg_len;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] can_id;
        logic [3:0]  dlc;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
        logic        last_frame;
    } out_item_t;

endpackage

FILE: rtl/n2k_fast_packet_framer_unit.sv
// A transaction accepted into the input register yields its frame (if any) in the
// result register when it leaves the update stage; out_valid rises with that write.
// Throughput: one byte per cycle while in_stall is low, set by the single update stage
// between the input and result registers; in_stall rises only while out_stall holds a frame.
// Reset (rst_n, async, active low): no message open, state cleared, source address 4.
module n2k_fast_packet_framer_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  n2k_fpf_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output n2k_fpf_pkg::out_item_t out_data,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data
);

    // Registers
    logic                   s1_valid_reg;
    n2k_fpf_pkg::in_item_t  s1_item_reg;
    logic                   out_valid_reg;
    n2k_fpf_pkg::out_item_t out_item_reg;
    logic [7:0]             src_addr_reg;

    logic [31:0]            held_id_reg,   held_id_next;
    logic [7:0]             held_len_reg,  held_len_next;
    logic [7:0]             left_reg,      left_next;
    logic [4:0]             index_reg,     index_next;
    logic [7:0]             buf_reg  [n2k_fpf_pkg::FRAME_BYTES];
    logic [7:0]             buf_next [n2k_fpf_pkg::FRAME_BYTES];
    logic [3:0]             fill_reg,      fill_next;
    logic                   drop_reg,      drop_next;

    // Combinational results of the update stage
    logic                   produce;
    logic                   advance;
    logic                   out_free;
    n2k_fpf_pkg::out_item_t frame;
    logic [3:0]             frame_dlc;
    logic                   frame_last;
    logic [7:0]             frame_bytes [n2k_fpf_pkg::FRAME_BYTES];
    logic [31:0]            new_id;
    logic                   pgn_bad;
    logic                   take_byte;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && (out_free || !produce);
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Identifier built from the header of the current item
    always_comb
    begin
        new_id = n2k_fpf_pkg::EFF_FLAG;
        new_id[7:0] = src_addr_reg;
        new_id[n2k_fpf_pkg::DST_SHIFT +: n2k_fpf_pkg::PGN_BITS] =
            s1_item_reg.pgn[n2k_fpf_pkg::PGN_BITS-1:0];
        if (s1_item_reg.pgn[7:0] == 8'd0)
        begin
            new_id[n2k_fpf_pkg::DST_SHIFT +: 8] = s1_item_reg.destination;
        end
        new_id[n2k_fpf_pkg::PRIO_SHIFT +: n2k_fpf_pkg::PRIO_BITS] = s1_item_reg.priority_req;
    end

    assign pgn_bad = (s1_item_reg.pgn[23:n2k_fpf_pkg::PGN_BITS] != '0);

    // Per-byte update: next framer state and the frame it completes
    always_comb
    begin
        held_id_next  = held_id_reg;
        held_len_next = held_len_reg;
        left_next     = left_reg;
        index_next    = index_reg;
        fill_next     = fill_reg;
        drop_next     = drop_reg;
        buf_next      = buf_reg;
        produce       = 1'b0;
        frame_dlc     = 4'd0;
        frame_last    = 1'b0;
        take_byte     = 1'b0;

        if (s1_item_reg.first)
        begin
            // New message: clear the frame in progress
            for (int i = 0; i < n2k_fpf_pkg::FRAME_BYTES; i++)
            begin
                buf_next[i] = 8'd0;
            end
            fill_next  = 4'd0;
            index_next = 5'd0;
            if (pgn_bad)
            begin
                drop_next = 1'b1;
                left_next = 8'd0;
            end
            else
            begin
                drop_next     = 1'b0;
                held_id_next  = new_id;
                held_len_next = s1_item_reg.msg_len;
                left_next     = s1_item_reg.msg_len;
                if (s1_item_reg.msg_len == 8'd0)
                begin
                    // Empty message: one empty final frame
                    produce    = 1'b1;
                    frame_last = 1'b1;
                end
                else
                begin
                    take_byte = 1'b1;
                end
            end
        end
        else if (!drop_reg && left_reg != 8'd0)
        begin
            take_byte = 1'b1;
        end

        if (take_byte)
        begin
            if (held_len_next > 8'(n2k_fpf_pkg::FRAME_BYTES))
            begin
                // Fast packet: header bytes at the start of each frame
                if (fill_next == 4'd0)
                begin
                    buf_next[0] = {3'b000, index_next};
                    if (index_next == 5'd0)
                    begin
                        buf_next[1] = held_len_next;
                        fill_next   = n2k_fpf_pkg::FILL_HDR_FIRST;
                    end
                    else
                    begin
                        fill_next = n2k_fpf_pkg::FILL_HDR_NEXT;
                    end
                end
                buf_next[fill_next[2:0]] = s1_item_reg.data_byte;
                fill_next = fill_next + 4'd1;
                left_next = left_next - 8'd1;
                if (fill_next[3] || left_next == 8'd0)
                begin
                    produce    = 1'b1;
                    frame_dlc  = fill_next;
                    frame_last = (left_next == 8'd0);
                    index_next = index_next + 5'd1;
                end
            end
            else
            begin
                // Single frame
                buf_next[fill_next[2:0]] = s1_item_reg.data_byte;
                fill_next = fill_next + 4'd1;
                left_next = left_next - 8'd1;
                if (left_next == 8'd0)
                begin
                    produce    = 1'b1;
                    frame_dlc  = held_len_next[3:0];
                    frame_last = 1'b1;
                end
            end
        end

        // Frame data, zero at and beyond dlc
        for (int i = 0; i < n2k_fpf_pkg::FRAME_BYTES; i++)
        begin
            frame_bytes[i] = (4'(i) < frame_dlc) ? buf_next[i] : 8'd0;
        end

        // Buffer empties once its frame is sent
        if (produce)
        begin
            for (int i = 0; i < n2k_fpf_pkg::FRAME_BYTES; i++)
            begin
                buf_next[i] = 8'd0;
            end
            fill_next = 4'd0;
        end
    end

    // Frame assembly
    always_comb
    begin
        frame.can_id     = held_id_next;
        frame.dlc        = frame_dlc;
        frame.byte0      = frame_bytes[0];
        frame.byte1      = frame_bytes[1];
        frame.byte2      = frame_bytes[2];
        frame.byte3      = frame_bytes[3];
        frame.byte4      = frame_bytes[4];
        frame.byte5      = frame_bytes[5];
        frame.byte6      = frame_bytes[6];
        frame.byte7      = frame_bytes[7];
        frame.last_frame = frame_last;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_item_reg <= frame;
        end
    end

    // Source address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg <= n2k_fpf_pkg::SRC_RESET;
        end
        else if (cfg_wr_en)
        begin
            src_addr_reg <= cfg_wr_data;
        end
    end

    // Framer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_id_reg  <= 32'd0;
            held_len_reg <= 8'd0;
            left_reg     <= 8'd0;
            index_reg    <= 5'd0;
            fill_reg     <= 4'd0;
            drop_reg     <= 1'b0;
            for (int i = 0; i < n2k_fpf_pkg::FRAME_BYTES; i++)
            begin
                buf_reg[i] <= 8'd0;
            end
        end
        else if (advance)
        begin
            held_id_reg  <= held_id_next;
            held_len_reg <= held_len_next;
            left_reg     <= left_next;
            index_reg    <= index_next;
            fill_reg     <= fill_next;
            drop_reg     <= drop_next;
            buf_reg      <= buf_next;
        end
    end

endmodule
